### rtl/pgmp_pkg.sv
// Shared constants, types and codes of the PGM-to-palette character decoder.
package pgmp_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int VALUE_BITS    = 16;
  localparam int STORE_SIZE    = 256;
  localparam int PAL_AW        = $clog2(STORE_SIZE);
  localparam int CMP_W         = 33;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] TOK_WIDTH = 3'd2;
  localparam logic [2:0] TOK_PIXEL = 3'd5;

  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_PAL_WR = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef logic [VALUE_BITS-1:0] value_t;

  // One closed pixel token and what it leads to.
  typedef struct packed {
    logic pix;       // a pixel result is due
    logic oor;       // value at or past the palette depth
    logic in_store;  // value addresses a real palette entry
    logic nl;        // a row-end newline follows the pixel
  } pix_evt_t;

endpackage

### rtl/pgm_ascii_to_palette_chars.sv
// Top level of the plain-text PGM decoder that maps pixels to palette characters.
// Datapath: a pixel's character passes through the palette read register and then the output
//   register, which it enters once the output can take a new result.
// Throughput: one request per cycle while out_tready is high, except while a pixel waits
//   behind a pending row-end newline, which goes out first and holds in_tready low.
// Reset: rst_n (synchronous, active low) clears the parser and result stage; the
//   palette memory is not cleared and holds whatever was written.
module pgm_ascii_to_palette_chars (
  input  logic        clk,
  input  logic        rst_n,
  // Input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // [7:0] data_byte, [15:8] palette_index, [23:16] palette_char
  input  logic [1:0]  in_tuser,  // [1:0] action
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // [7:0] out_char
  output logic        out_tuser, // [0] index_out_of_range
  output logic        out_tlast  // last result caused by this request
);
  import pgmp_pkg::*;

  logic               accept;
  action_t            action;
  logic [7:0]         data_byte, palette_index, palette_char;
  logic               byte_en, clear_en, pal_wr_en, load;
  pix_evt_t           evt;
  logic [PAL_AW-1:0]  rd_addr;
  logic [7:0]         rd_data;

  // Unpack the request.
  assign data_byte     = in_tdata[7:0];
  assign palette_index = in_tdata[15:8];
  assign palette_char  = in_tdata[23:16];
  assign action        = action_t'(in_tuser);

  assign accept = in_tvalid && in_tready;

  // Decode the request kind; the unused code falls through and does nothing.
  always_comb begin
    byte_en   = 1'b0;
    clear_en  = 1'b0;
    pal_wr_en = 1'b0;
    if (accept) begin
      case (action)
        ACT_BYTE:   byte_en  = 1'b1;
        ACT_CLEAR:  clear_en = 1'b1;
        ACT_PAL_WR: pal_wr_en = CMP_W'(palette_index) < CMP_W'(PALETTE_DEPTH);
        default:    ;
      endcase
    end
  end

  // A closing pixel token reads the palette and loads the result stage.
  assign load = byte_en && evt.pix;

  pgmp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .clear_en  (clear_en),
    .data_byte (data_byte),
    .evt       (evt),
    .rd_addr   (rd_addr)
  );

  // A write always lands in memory before any later pixel read samples it, so
  // no forwarding is needed.
  pgmp_palette_ram u_palette (
    .clk     (clk),
    .wr_en   (pal_wr_en),
    .wr_addr (palette_index[PAL_AW-1:0]),
    .wr_data (palette_char),
    .rd_en   (load),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pgmp_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .evt        (evt),
    .rd_data    (rd_data),
    .s1_free    (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_tdata),
    .out_oor    (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

### rtl/pgmp_palette_ram.sv
// Palette memory: one write port, one registered read port.
module pgmp_palette_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [pgmp_pkg::PAL_AW-1:0] wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic                       rd_en,
  input  logic [pgmp_pkg::PAL_AW-1:0] rd_addr,
  output logic [7:0]                 rd_data
);
  import pgmp_pkg::*;

  logic [7:0] mem [STORE_SIZE];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the last read while no new pixel reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/pgmp_parser.sv
// Text parser: comments, tokens, width capture and row counting.
module pgmp_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_en,
  input  logic                        clear_en,
  input  logic [7:0]                  data_byte,
  output pgmp_pkg::pix_evt_t          evt,
  output logic [pgmp_pkg::PAL_AW-1:0] rd_addr
);
  import pgmp_pkg::*;

  localparam int MW = VALUE_BITS + 4;

  logic        in_comment_r, in_comment_nxt;
  logic        tok_open_r, tok_open_nxt;
  logic [2:0]  tok_cnt_r, tok_cnt_nxt;
  value_t      acc_r, acc_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] col_r, col_nxt;

  logic        cm, blank, digit, closing;
  logic [2:0]  tc_inc;
  logic [15:0] col_inc, width_sat;
  logic [MW-1:0] prod;

  always_comb begin
    cm      = in_comment_r || (data_byte == CH_HASH);
    blank   = (data_byte == CH_SPACE) || (data_byte inside {[CH_TAB:CH_CR]});
    digit   = data_byte inside {[CH_ZERO:CH_NINE]};
    closing = !cm && blank && tok_open_r;
    tc_inc  = (tok_cnt_r < TOK_PIXEL) ? tok_cnt_r + 3'd1 : tok_cnt_r;
    col_inc = col_r + 16'd1;
    width_sat = ({16'd0, acc_r} > (VALUE_BITS+16)'(17'h0FFFF)) ? 16'hFFFF : 16'(acc_r);
    prod = (MW'(acc_r) << 3) + (MW'(acc_r) << 1) + MW'(data_byte[3:0]);

    in_comment_nxt = in_comment_r;
    tok_open_nxt   = tok_open_r;
    tok_cnt_nxt    = tok_cnt_r;
    acc_nxt        = acc_r;
    width_nxt      = width_r;
    col_nxt        = col_r;

    evt.pix      = 1'b0;
    evt.nl       = 1'b0;
    evt.oor      = CMP_W'(acc_r) >= CMP_W'(PALETTE_DEPTH);
    evt.in_store = CMP_W'(acc_r) < CMP_W'(STORE_SIZE);
    rd_addr      = acc_r[PAL_AW-1:0];

    if (byte_en) begin
      if (closing) begin
        tok_cnt_nxt = tc_inc;
        if (tc_inc == TOK_WIDTH) begin
          width_nxt = width_sat;
        end
        if (tc_inc == TOK_PIXEL) begin
          evt.pix = 1'b1;
          col_nxt = col_inc;
          if (width_r != 16'd0 && col_inc == width_r) begin
            evt.nl  = 1'b1;
            col_nxt = 16'd0;
          end
        end
        acc_nxt = '0;
      end
      if (!cm && blank) begin
        tok_open_nxt = 1'b0;
      end
      if (!cm && digit) begin
        tok_open_nxt = 1'b1;
        acc_nxt = (prod[MW-1:VALUE_BITS] != '0) ? '1 : prod[VALUE_BITS-1:0];
      end
      in_comment_nxt = cm && (data_byte != CH_NL);
    end

    if (clear_en) begin
      in_comment_nxt = 1'b0;
      tok_open_nxt   = 1'b0;
      tok_cnt_nxt    = 3'd0;
      acc_nxt        = '0;
      width_nxt      = 16'd0;
      col_nxt        = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_comment_r <= 1'b0;
      tok_open_r   <= 1'b0;
      tok_cnt_r    <= 3'd0;
      acc_r        <= '0;
      width_r      <= 16'd0;
      col_r        <= 16'd0;
    end else begin
      in_comment_r <= in_comment_nxt;
      tok_open_r   <= tok_open_nxt;
      tok_cnt_r    <= tok_cnt_nxt;
      acc_r        <= acc_nxt;
      width_r      <= width_nxt;
      col_r        <= col_nxt;
    end
  end

  a_tok_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    tok_cnt_r <= TOK_PIXEL)
    else $error("token count past saturation");

  a_col_below_width: assert property (@(posedge clk) disable iff (!rst_n)
    (width_r != 16'd0) |-> (col_r < width_r))
    else $error("column count reached row width without wrapping");

  a_no_pixel_before_header: assert property (@(posedge clk) disable iff (!rst_n)
    evt.pix |-> (tok_cnt_r >= 3'd4))
    else $error("pixel result before the header is complete");

endmodule

### rtl/pgmp_emit.sv
// Result stage: holds one pixel request and drives results out one at a time.
module pgmp_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  pgmp_pkg::pix_evt_t evt,
  input  logic [7:0]         rd_data,
  output logic               s1_free,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_char,
  output logic               out_oor,
  output logic               out_last
);
  import pgmp_pkg::*;

  logic s1_pix_r, s1_pix_nxt;
  logic s1_nl_r, s1_nl_nxt;
  logic s1_oor_r, s1_oor_nxt;
  logic s1_store_r, s1_store_nxt;
  logic nl_pend_r, nl_pend_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic out_oor_r, out_oor_nxt;
  logic out_last_r, out_last_nxt;

  logic out_load, emit_pix, emit_nl;

  always_comb begin
    out_load = !out_valid_r || out_tready;
    // A pending row-end newline goes out ahead of the next pixel.
    emit_nl  = out_load && nl_pend_r;
    emit_pix = out_load && !nl_pend_r && s1_pix_r;
    s1_free  = !s1_pix_r || (out_load && !nl_pend_r);

    s1_pix_nxt   = s1_pix_r && !emit_pix;
    s1_nl_nxt    = s1_nl_r;
    s1_oor_nxt   = s1_oor_r;
    s1_store_nxt = s1_store_r;
    nl_pend_nxt  = (nl_pend_r && !emit_nl) || (emit_pix && s1_nl_r);
    if (load) begin
      s1_pix_nxt   = 1'b1;
      s1_nl_nxt    = evt.nl;
      s1_oor_nxt   = evt.oor;
      s1_store_nxt = evt.in_store;
    end

    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_oor_nxt   = out_oor_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = emit_pix || emit_nl;
      if (emit_pix) begin
        out_char_nxt = (s1_oor_r || !s1_store_r) ? 8'd0 : rd_data;
        out_oor_nxt  = s1_oor_r;
        out_last_nxt = !s1_nl_r;
      end else if (emit_nl) begin
        out_char_nxt = CH_NL;
        out_oor_nxt  = 1'b0;
        out_last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pix_r    <= 1'b0;
      s1_nl_r     <= 1'b0;
      nl_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_pix_r    <= s1_pix_nxt;
      s1_nl_r     <= s1_nl_nxt;
      nl_pend_r   <= nl_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_oor_r   <= s1_oor_nxt;
    s1_store_r <= s1_store_nxt;
    out_char_r <= out_char_nxt;
    out_oor_r  <= out_oor_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_oor    = out_oor_r;
  assign out_last   = out_last_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> s1_free)
    else $error("pixel request loaded over a pending one");

  a_oor_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> (out_char_r == 8'd0))
    else $error("out-of-range result carries a character");

  a_newline_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> nl_pend_r)
    else $error("non-final result without a pending newline");

  a_nl_needs_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (load && evt.nl) |=> (s1_pix_r && s1_nl_r))
    else $error("newline request lost on load");

endmodule
